// ===== design/rdt_pkg.sv =====
// Package with the shared types and constants of the rotary detent tracker.
`default_nettype none
package rdt_pkg;

  localparam int unsigned MotionAvgShift  = 3;
  localparam int unsigned CentrePullShift = 4;

  localparam logic [2:0] REG_DETENT_WIDTH     = 3'd0;
  localparam logic [2:0] REG_SNAP_FRACTION    = 3'd1;
  localparam logic [2:0] REG_SNAP_BIAS        = 3'd2;
  localparam logic [2:0] REG_LOWEST_POSITION  = 3'd3;
  localparam logic [2:0] REG_HIGHEST_POSITION = 3'd4;
  localparam logic [2:0] REG_IDLE_SPEED_LIMIT = 3'd5;
  localparam logic [2:0] REG_IDLE_DELAY_MS    = 3'd6;
  localparam logic [2:0] REG_IDLE_MAX_OFFSET  = 3'd7;

  localparam logic [18:0] DetentWidthReset    = 19'd68629;
  localparam logic [15:0] SnapFractionReset   = 16'd282;
  localparam logic [15:0] SnapFractionMin     = 16'd128;
  localparam logic [31:0] HighestPosReset     = 32'd1;
  localparam logic [30:0] IdleSpeedLimitReset = 31'd655;
  localparam logic [15:0] IdleDelayReset      = 16'd500;
  localparam logic [30:0] IdleMaxOffsetReset  = 31'd6554;

  localparam logic [0:0] ACTION_SAMPLE = 1'b0;
  localparam logic [0:0] ACTION_PRESET = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOTION,
    S_AVERAGE,
    S_IDLECHK,
    S_PULL,
    S_PULL2,
    S_DIFF,
    S_STEP,
    S_DIVSET,
    S_DIV,
    S_PRESET,
    S_PRESET2,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== design/rdt_channels.sv =====
// Channel interfaces for the sample input and the position result of the tracker.
`default_nettype none
interface rdt_sample_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] angle;
  logic        [31:0] now_ms;
  logic signed [31:0] preset_position;
  logic signed [15:0] preset_sub_position;

  modport source (output valid, action, angle, now_ms, preset_position,
                  preset_sub_position, input ready);
  modport sink (input valid, action, angle, now_ms, preset_position,
                preset_sub_position, output ready);
endinterface

interface rdt_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [15:0] sub_position;
  logic               stepped;

  modport source (output valid, position, sub_position, stepped, input ready);
  modport sink (input valid, position, sub_position, stepped, output ready);
endinterface
`default_nettype wire

// ===== design/rotary_detent_tracker_unit.sv =====
// Rotary detent tracker: follows knob angle samples and reports the detent position.
// An angle sample passes from acceptance to result through eight sequencer steps that
// share one 20 by 17 bit multiplier, and a restoring divider then produces the 16 bit
// sub-position quotient one bit per cycle. Samples whose quotient would overflow 16 bits
// skip the divider, and a preset bypasses it as well. The sample input is ready only while
// the sequencer is idle, and the result sits in an output register, so a new transaction
// is taken while the previous result still waits to be read.
`default_nettype none
module rotary_detent_tracker_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  rdt_sample_if.sink       samples,
  rdt_result_if.source     results
);

  rdt_pkg::state_t state, state_next;

  logic [18:0]        width_r;
  logic [15:0]        snap_frac;
  logic [15:0]        bias_frac;
  logic signed [31:0] low_pos;
  logic signed [31:0] high_pos;
  logic [30:0]        idle_speed;
  logic [15:0]        idle_delay;
  logic [30:0]        idle_offset;

  logic               act;
  logic signed [31:0] ang;
  logic [31:0]        now_r;
  logic signed [31:0] pre_pos;
  logic signed [15:0] pre_sub;

  logic signed [31:0] idx;
  logic signed [31:0] cen;
  logic signed [15:0] last_sub;
  logic signed [31:0] last_ang;
  logic signed [31:0] prev;
  logic               prev_valid;
  logic [32:0]        avg;
  logic [31:0]        idle_since;
  logic               idle_running;

  logic [32:0]        ad;
  logic signed [36:0] prod;
  logic signed [16:0] mul_b;
  logic [26:0]        snap_amt;
  logic [26:0]        bias_amt;
  logic signed [32:0] pull_diff;
  logic signed [33:0] diff;
  logic signed [33:0] dec_th;
  logic signed [33:0] inc_th;
  logic               ovf;
  logic [18:0]        rem;
  logic [15:0]        shreg;
  logic [15:0]        quo;
  logic [3:0]         cnt;
  logic               changed_r;

  logic               out_valid;
  logic signed [31:0] out_pos;
  logic               out_chg;

  logic               accept;
  logic               load;
  logic               bounded;
  logic signed [32:0] d;
  logic [32:0]        pmag;
  logic [31:0]        elapsed;
  logic signed [33:0] snapx;
  logic signed [33:0] biasx;
  logic signed [33:0] wx;
  logic [33:0]        absd;
  logic [19:0]        trial;
  logic [15:0]        sat_sub;
  logic [15:0]        sub_value;

  assign accept  = samples.valid && samples.ready;
  assign bounded = low_pos <= high_pos;
  assign load    = (state == rdt_pkg::S_FINISH) && (!out_valid || results.ready);

  assign samples.ready        = (state == rdt_pkg::S_IDLE);
  assign results.valid        = out_valid;
  assign results.position     = out_pos;
  assign results.sub_position = last_sub;
  assign results.stepped      = out_chg;

  assign d       = {ang[31], ang} - {prev[31], prev};
  assign pmag    = pull_diff[32] ? 33'(-pull_diff) : 33'(pull_diff);
  assign elapsed = now_r - idle_since;
  assign snapx   = $signed({7'b0, snap_amt});
  assign biasx   = $signed({7'b0, bias_amt});
  assign wx      = $signed({15'b0, width_r});
  assign absd    = diff[33] ? 34'(-diff) : 34'(diff);
  assign trial   = {rem, shreg[15]};

  always_comb begin
    case (state)
      rdt_pkg::S_MOTION:  mul_b = $signed({1'b0, snap_frac});
      rdt_pkg::S_AVERAGE: mul_b = $signed({1'b0, bias_frac});
      default:            mul_b = $signed({pre_sub[15], pre_sub});
    endcase
  end

  always_comb begin
    if (!diff[33] && (diff != 34'sd0)) begin
      sat_sub = (ovf || (quo > 16'h8000)) ? 16'h8000 : 16'(~quo + 16'd1);
    end else begin
      sat_sub = (ovf || quo[15]) ? 16'h7FFF : quo;
    end
    sub_value = (act == rdt_pkg::ACTION_PRESET) ? pre_sub : sat_sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (samples.action == rdt_pkg::ACTION_PRESET) ? rdt_pkg::S_PRESET :
                                                                   rdt_pkg::S_MOTION;
        end
      end
      rdt_pkg::S_MOTION:  state_next = rdt_pkg::S_AVERAGE;
      rdt_pkg::S_AVERAGE: state_next = rdt_pkg::S_IDLECHK;
      rdt_pkg::S_IDLECHK: state_next = rdt_pkg::S_PULL;
      rdt_pkg::S_PULL:    state_next = rdt_pkg::S_PULL2;
      rdt_pkg::S_PULL2:   state_next = rdt_pkg::S_DIFF;
      rdt_pkg::S_DIFF:    state_next = rdt_pkg::S_STEP;
      rdt_pkg::S_STEP:    state_next = rdt_pkg::S_DIVSET;
      rdt_pkg::S_DIVSET: begin
        state_next = (absd >= {7'b0, width_r, 8'b0}) ? rdt_pkg::S_FINISH : rdt_pkg::S_DIV;
      end
      rdt_pkg::S_DIV: begin
        if (cnt == 4'd15) begin
          state_next = rdt_pkg::S_FINISH;
        end
      end
      rdt_pkg::S_PRESET:  state_next = rdt_pkg::S_PRESET2;
      rdt_pkg::S_PRESET2: state_next = rdt_pkg::S_FINISH;
      rdt_pkg::S_FINISH: begin
        if (load) begin
          state_next = rdt_pkg::S_IDLE;
        end
      end
      default: state_next = rdt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r     <= rdt_pkg::DetentWidthReset;
      snap_frac   <= rdt_pkg::SnapFractionReset;
      bias_frac   <= '0;
      low_pos     <= '0;
      high_pos    <= rdt_pkg::HighestPosReset;
      idle_speed  <= rdt_pkg::IdleSpeedLimitReset;
      idle_delay  <= rdt_pkg::IdleDelayReset;
      idle_offset <= rdt_pkg::IdleMaxOffsetReset;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        rdt_pkg::REG_DETENT_WIDTH: begin
          if (cfg_data[18:0] != 19'd0) begin
            width_r <= cfg_data[18:0];
          end
        end
        rdt_pkg::REG_SNAP_FRACTION: begin
          if (cfg_data[15:0] >= rdt_pkg::SnapFractionMin) begin
            snap_frac <= cfg_data[15:0];
          end
        end
        rdt_pkg::REG_SNAP_BIAS:        bias_frac   <= cfg_data[15:0];
        rdt_pkg::REG_LOWEST_POSITION:  low_pos     <= $signed(cfg_data);
        rdt_pkg::REG_HIGHEST_POSITION: high_pos    <= $signed(cfg_data);
        rdt_pkg::REG_IDLE_SPEED_LIMIT: idle_speed  <= cfg_data[30:0];
        rdt_pkg::REG_IDLE_DELAY_MS:    idle_delay  <= cfg_data[15:0];
        rdt_pkg::REG_IDLE_MAX_OFFSET:  idle_offset <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, width_r}) * mul_b;
    if (accept) begin
      act     <= samples.action;
      ang     <= samples.angle;
      now_r   <= samples.now_ms;
      pre_pos <= samples.preset_position;
      pre_sub <= samples.preset_sub_position;
    end
    case (state)
      rdt_pkg::S_MOTION: begin
        ad <= !prev_valid ? '0 : (d[32] ? 33'(-d) : 33'(d));
      end
      rdt_pkg::S_AVERAGE: snap_amt <= prod[34:8];
      rdt_pkg::S_IDLECHK: bias_amt <= prod[34:8];
      rdt_pkg::S_PULL:    pull_diff <= {ang[31], ang} - {cen[31], cen};
      rdt_pkg::S_DIFF: begin
        diff   <= {{2{ang[31]}}, ang} - {{2{cen[31]}}, cen};
        dec_th <= (idx <= 32'sd0) ? (snapx + biasx) : (snapx - biasx);
        inc_th <= (idx >= 32'sd0) ? (-snapx - biasx) : (biasx - snapx);
      end
      rdt_pkg::S_STEP: begin
        if ((diff > dec_th) && (!bounded || (idx > low_pos))) begin
          diff <= diff - wx;
        end else if ((diff < inc_th) && (!bounded || (idx < high_pos))) begin
          diff <= diff + wx;
        end
      end
      rdt_pkg::S_DIVSET: begin
        ovf   <= absd >= {7'b0, width_r, 8'b0};
        rem   <= absd[26:8];
        shreg <= {absd[7:0], 8'h00};
        quo   <= '0;
        cnt   <= '0;
      end
      rdt_pkg::S_DIV: begin
        if (trial >= {1'b0, width_r}) begin
          rem <= 19'(trial - {1'b0, width_r});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= trial[18:0];
          quo <= {quo[14:0], 1'b0};
        end
        shreg <= {shreg[14:0], 1'b0};
        cnt   <= cnt + 4'd1;
      end
      default: ;
    endcase
    if (load) begin
      out_pos <= idx;
      out_chg <= changed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      cen          <= '0;
      last_sub     <= '0;
      last_ang     <= '0;
      prev         <= '0;
      prev_valid   <= 1'b0;
      avg          <= '0;
      idle_since   <= '0;
      idle_running <= 1'b0;
      changed_r    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        rdt_pkg::S_MOTION: begin
          last_ang   <= ang;
          prev       <= ang;
          prev_valid <= 1'b1;
        end
        rdt_pkg::S_AVERAGE: begin
          if (ad >= avg) begin
            avg <= avg + ((ad - avg) >> rdt_pkg::MotionAvgShift);
          end else begin
            avg <= avg - ((avg - ad) >> rdt_pkg::MotionAvgShift);
          end
        end
        rdt_pkg::S_IDLECHK: begin
          if (avg > {2'b0, idle_speed}) begin
            idle_running <= 1'b0;
          end else if (!idle_running) begin
            idle_running <= 1'b1;
            idle_since   <= now_r;
          end
        end
        rdt_pkg::S_PULL2: begin
          if (idle_running && (elapsed > {16'b0, idle_delay}) &&
              (pmag < {2'b0, idle_offset})) begin
            if (!pull_diff[32]) begin
              cen <= cen + $signed(32'(pmag >> rdt_pkg::CentrePullShift));
            end else begin
              cen <= cen - $signed(32'(pmag >> rdt_pkg::CentrePullShift));
            end
          end
        end
        rdt_pkg::S_STEP: begin
          if ((diff > dec_th) && (!bounded || (idx > low_pos))) begin
            cen       <= cen + $signed({13'b0, width_r});
            idx       <= idx - 32'sd1;
            changed_r <= 1'b1;
          end else if ((diff < inc_th) && (!bounded || (idx < high_pos))) begin
            cen       <= cen - $signed({13'b0, width_r});
            idx       <= idx + 32'sd1;
            changed_r <= 1'b1;
          end else begin
            changed_r <= 1'b0;
          end
        end
        rdt_pkg::S_PRESET: begin
          changed_r <= 1'b0;
          if (bounded && (pre_pos < low_pos)) begin
            idx <= low_pos;
          end else if (bounded && (pre_pos > high_pos)) begin
            idx <= high_pos;
          end else begin
            idx <= pre_pos;
          end
        end
        rdt_pkg::S_PRESET2: begin
          cen <= last_ang + 32'(prod >>> 8);
        end
        default: ;
      endcase
      if (load) begin
        last_sub  <= $signed(sub_value);
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == rdt_pkg::S_MOTION || state == rdt_pkg::S_PRESET))
    else $error("accepted transaction did not start the sequencer");

  a_rem_bounded : assert property (@(posedge clk) disable iff (rst)
    (state == rdt_pkg::S_DIV) |-> (rem < width_r))
    else $error("divider remainder not below the detent width");

  a_preset_no_change : assert property (@(posedge clk) disable iff (rst)
    (state == rdt_pkg::S_FINISH && act == rdt_pkg::ACTION_PRESET) |-> !changed_r)
    else $error("preset flagged a position step");

  a_finish_loads : assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && state == rdt_pkg::S_IDLE))
    else $error("finished result not held in the output register");

endmodule
`default_nettype wire
